[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/csvt_pkg.sv]
// Shared types, constants and helpers of the CSV field tokenizer.
`timescale 1ns / 1ps
package csvt_pkg;

  localparam int unsigned HOLD_DEPTH_DEF = 32;
  // Width of the count carried in a command; covers every legal hold depth.
  localparam int unsigned CNT_FIELD_W    = 6;

  localparam logic [7:0] QUOTE_CH = 8'h22;
  localparam logic [7:0] COMMA_CH = 8'h2C;

  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic       ws_overflow;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    QM_OUT,
    QM_IN,
    QM_PEND
  } qmode_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_FLUSH,
    CMD_FIELD_END,
    CMD_LINE_END
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [7:0]             ch;
    logic [CNT_FIELD_W-1:0] cnt;
    logic                   ovf;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WS,
    BK_CHAR
  } back_state_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'd9:8'd13], 8'd32, 8'd133, 8'd160};
  endfunction

endpackage

[rtl/csvt_fifo.sv]
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps
module csvt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/csvt_front.sv]
// Front end: accepts characters, tracks quoting and trimming, issues commands.
`timescale 1ns / 1ps
module csvt_front import csvt_pkg::*; #(
  parameter int unsigned HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     cmd_wr,
  output cmd_t     cmd,
  input  logic     cmdq_full
);

  localparam int unsigned CNT_W = $clog2(HOLD_DEPTH + 1);

  qmode_t           qmode_r, qmode_nxt;
  logic             started_r, started_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;
  logic [7:0]       c;
  logic             use_ch, end_fld, outside;

  assign full   = cmdq_full;
  assign accept = push && !cmdq_full;
  assign c      = in_item.char_code;

  // Next quoting state and classification of the character.
  always_comb begin
    qmode_nxt = qmode_r;
    use_ch    = 1'b0;
    end_fld   = 1'b0;
    outside   = 1'b0;
    if (accept) begin
      if (in_item.action) begin
        qmode_nxt = QM_OUT;
      end else begin
        case (qmode_r)
          QM_IN: begin
            if (c == QUOTE_CH) qmode_nxt = QM_PEND;
            else               use_ch    = 1'b1;
          end
          QM_PEND: begin
            // doubled quote gives a literal quote, anything else closes quoting
            if (c == QUOTE_CH) begin
              qmode_nxt = QM_IN;
              use_ch    = 1'b1;
            end else begin
              outside = 1'b1;
            end
          end
          default: outside = 1'b1;
        endcase
        if (outside) begin
          qmode_nxt = QM_OUT;
          if (c == QUOTE_CH)      qmode_nxt = QM_IN;
          else if (c == COMMA_CH) end_fld   = 1'b1;
          else                    use_ch    = 1'b1;
        end
      end
    end
  end

  // Trimming counters and the command for the back end.
  always_comb begin
    started_nxt = started_r;
    held_nxt    = held_r;
    ovf_nxt     = ovf_r;
    cmd_wr      = 1'b0;
    cmd         = '{op: CMD_HOLD, ch: c, cnt: CNT_FIELD_W'(held_r), ovf: ovf_r};
    if (accept && (in_item.action || end_fld)) begin
      cmd_wr      = 1'b1;
      cmd.op      = in_item.action ? CMD_LINE_END : CMD_FIELD_END;
      held_nxt    = '0;
      ovf_nxt     = 1'b0;
      started_nxt = 1'b0;
    end else if (use_ch) begin
      if (is_space(c)) begin
        if (started_r) begin
          if (held_r < CNT_W'(HOLD_DEPTH)) begin
            cmd_wr   = 1'b1;
            cmd.op   = CMD_HOLD;
            held_nxt = held_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end else begin
        cmd_wr      = 1'b1;
        cmd.op      = CMD_FLUSH;
        held_nxt    = '0;
        ovf_nxt     = 1'b0;
        started_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qmode_r   <= QM_OUT;
      started_r <= 1'b0;
      held_r    <= '0;
      ovf_r     <= 1'b0;
    end else begin
      qmode_r   <= qmode_nxt;
      started_r <= started_nxt;
      held_r    <= held_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

[rtl/csvt_back.sv]
// Back end: stores held whitespace and turns commands into result items.
`timescale 1ns / 1ps
module csvt_back import csvt_pkg::*; #(
  parameter int unsigned HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmdq_empty,
  input  cmd_t      cmd,
  output logic      cmd_rd,
  input  logic      outq_full,
  output logic      res_wr,
  output out_item_t res
);

  localparam int unsigned IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  logic [7:0]       hold_mem [HOLD_DEPTH];
  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, rd_addr, ws_last_r;
  logic [7:0]       ch_r, rd_data_r;
  logic             ovf_r;
  logic             mem_we, flush_take;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmdq_empty && cmd.op == CMD_FLUSH) begin
          state_nxt = (cmd.cnt == '0) ? BK_CHAR : BK_WS;
        end
      end
      BK_WS: begin
        if (!outq_full && idx_r == ws_last_r) state_nxt = BK_CHAR;
      end
      BK_CHAR: begin
        if (!outq_full) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs, read address and index advance.
  always_comb begin
    cmd_rd     = 1'b0;
    res_wr     = 1'b0;
    res        = '{kind: KIND_CHAR, out_char: 8'd0, ws_overflow: 1'b0, last: 1'b0};
    mem_we     = 1'b0;
    flush_take = 1'b0;
    rd_addr    = idx_r;
    idx_nxt    = idx_r;
    case (state_r)
      BK_IDLE: begin
        rd_addr = '0;
        idx_nxt = '0;
        if (!cmdq_empty) begin
          case (cmd.op)
            CMD_HOLD: begin
              cmd_rd = 1'b1;
              mem_we = 1'b1;
            end
            CMD_FLUSH: begin
              cmd_rd     = 1'b1;
              flush_take = 1'b1;
            end
            CMD_FIELD_END, CMD_LINE_END: begin
              res.kind = (cmd.op == CMD_LINE_END) ? KIND_LINE_END : KIND_FIELD_END;
              res.last = 1'b1;
              if (!outq_full) begin
                cmd_rd = 1'b1;
                res_wr = 1'b1;
              end
            end
            default: cmd_rd = 1'b1;
          endcase
        end
      end
      BK_WS: begin
        res.out_char    = rd_data_r;
        res.ws_overflow = ovf_r;
        if (!outq_full) begin
          res_wr = 1'b1;
          if (idx_r != ws_last_r) begin
            idx_nxt = idx_r + 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      BK_CHAR: begin
        res.out_char    = ch_r;
        res.ws_overflow = ovf_r;
        res.last        = 1'b1;
        res_wr          = !outq_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (flush_take) begin
      ch_r      <= cmd.ch;
      ovf_r     <= cmd.ovf;
      ws_last_r <= IDX_W'(cmd.cnt - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hold_mem[IDX_W'(cmd.cnt)] <= cmd.ch;
    end
    rd_data_r <= hold_mem[rd_addr];
  end

endmodule

[rtl/csv_field_tokenizer.sv]
// Top level of the CSV field tokenizer: front end, command queue, back end, result queue.
`timescale 1ns / 1ps
// Splits one CSV line, pushed one Latin-1 character per transaction and closed
// by an end-of-line transaction, into trimmed fields. Unquoted commas end a
// field; double quotes open and close quoting and a doubled quote inside
// quotes gives a literal quote. Leading and trailing whitespace of each field
// is dropped; inner whitespace is held (up to HOLD_DEPTH characters) and
// released only when more content follows, with ws_overflow set on that flush
// if any had to be dropped. Results are popped as character items, field ends
// and a final field-with-line end; last marks the final result of each input
// transaction. Throughput: the front end takes one transaction per cycle while
// its four-entry command queue has room. The back end stores a held whitespace
// character or turns a field end into a result; a flush emits the released
// held whitespace, read in turn from the hold memory, then the character, and
// takes no new command meanwhile; long flushes fill the queue and raise full.
module csv_field_tokenizer import csvt_pkg::*; #(
  parameter int unsigned HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned OUTQ_DEPTH = 2;

  logic      front_cmd_wr, cmdq_full, cmdq_empty, back_cmd_rd;
  cmd_t      front_cmd;
  logic [$bits(cmd_t)-1:0] cmdq_rd_data;
  logic      back_res_wr, outq_full;
  out_item_t back_res;
  logic [$bits(out_item_t)-1:0] outq_rd_data;

  // Classify each transaction and keep quoting and trimming state.
  csvt_front #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_wr    (front_cmd_wr),
    .cmd       (front_cmd),
    .cmdq_full (cmdq_full)
  );

  // Decouple the front end from flushes in progress at the back.
  csvt_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_cmd_wr),
    .wr_data (front_cmd),
    .full    (cmdq_full),
    .rd_en   (back_cmd_rd),
    .rd_data (cmdq_rd_data),
    .empty   (cmdq_empty)
  );

  // Hold whitespace and drive result items one per cycle while the result queue has room.
  csvt_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmdq_empty (cmdq_empty),
    .cmd        (cmd_t'(cmdq_rd_data)),
    .cmd_rd     (back_cmd_rd),
    .outq_full  (outq_full),
    .res_wr     (back_res_wr),
    .res        (back_res)
  );

  // Registered result queue: let the back end advance while a result waits.
  csvt_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (back_res_wr),
    .wr_data (back_res),
    .full    (outq_full),
    .rd_en   (pop),
    .rd_data (outq_rd_data),
    .empty   (empty)
  );

  assign out_item = out_item_t'(outq_rd_data);

endmodule

[rtl/csvt_checker.sv]
// Port-level checker of the CSV field tokenizer and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csvt_checker import csvt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> empty && !full, "queues not clear after reset")
  `ASSERT_ON(a_out_hold, !empty && !pop |=> !empty && $stable(out_item), "waiting result changed")
  `ASSERT_ON(a_full_needs_push, !full && !push |=> !full, "full rose without a transaction")
  `ASSERT_ON(a_end_shape, !empty && out_item.kind != KIND_CHAR |-> out_item.last && out_item.out_char == 8'd0 && !out_item.ws_overflow, "malformed field end")

endmodule

bind csv_field_tokenizer csvt_checker u_checker (.*);
